### rtl/core/motor_speed_ramp_stall_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor speed ramp and stall controller
// Concurrent check wrappers that vanish when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_RAMP_STALL_CONTROLLER_MACROS_SVH
`define MOTOR_SPEED_RAMP_STALL_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define MSSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MSSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MSSR_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define MSSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/mssr_pkg.sv
// ----------------------------------------------------------------------------
// Motor speed ramp and stall controller package
// Shared widths, codes, configuration and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package mssr_pkg;

   localparam int SPEED_W     = 16;
   localparam int RATE_W      = 14;
   localparam int CNT_W       = 16;
   localparam int CMD_W       = 2;
   localparam int STATE_W     = 2;
   // Ramp remainders always stay below the rate scale of one hundred.
   localparam int REM_W       = 7;
   localparam int ACC_W       = RATE_W + 1;
   localparam int STEP_W      = 8;
   localparam int SUM_W       = SPEED_W + 1;

   // Division by one hundred as a multiply by 5243 / 2^19, exact for ACC_W bits.
   localparam int RATE_SCALE  = 100;
   localparam int RECIP_MULT  = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = 28;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_ACCEL_RATE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECEL_RATE   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STOP_SPEED   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_STALL_LIMIT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOUNCE_LIMIT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_STALL_ENABLE = 3'd5;

   localparam logic [RATE_W-1:0] RST_ACCEL_RATE   = 14'd100;
   localparam logic [RATE_W-1:0] RST_DECEL_RATE   = 14'd100;
   localparam logic [SPEED_W-1:0] RST_STOP_SPEED  = 16'd100;
   localparam logic [CNT_W-1:0] RST_STALL_LIMIT   = 16'd1000;
   localparam logic [CNT_W-1:0] RST_BOUNCE_LIMIT  = 16'd100;
   localparam logic RST_STALL_ENABLE              = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_IDLE    = 2'd0,
      CMD_STOP    = 2'd1,
      CMD_FORWARD = 2'd2,
      CMD_REVERSE = 2'd3
   } work_cmd_type;

   typedef enum logic [STATE_W-1:0] {
      ST_IDLE = 2'd0,
      ST_RUN  = 2'd1,
      ST_ERR  = 2'd2
   } run_state_type;

   typedef struct packed {
      logic [RATE_W-1:0]  accel_rate;
      logic [RATE_W-1:0]  decel_rate;
      logic [SPEED_W-1:0] stop_speed;
      logic [CNT_W-1:0]   stall_limit;
      logic [CNT_W-1:0]   bounce_limit;
      logic               stall_enable;
   } cfg_type;

   typedef struct packed {
      logic [SPEED_W-1:0] reference_speed;
      logic [STATE_W-1:0] motor_state;
      logic               drive_enable;
      logic               integrator_clear;
      logic               stall_fault;
   } rsp_item_type;

endpackage

`default_nettype wire

### rtl/core/mssr_csr.sv
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the ramp rates, thresholds and stall enable written over the CSR port.
// ----------------------------------------------------------------------------
`default_nettype none

module mssr_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [mssr_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  wire logic [mssr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output mssr_pkg::cfg_type                      cfg
);
   import mssr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACCEL_RATE:   cfg_in.accel_rate   = csr_wdata[RATE_W-1:0];
            CSR_DECEL_RATE:   cfg_in.decel_rate   = csr_wdata[RATE_W-1:0];
            CSR_STOP_SPEED:   cfg_in.stop_speed   = csr_wdata[SPEED_W-1:0];
            CSR_STALL_LIMIT:  cfg_in.stall_limit  = csr_wdata[CNT_W-1:0];
            CSR_BOUNCE_LIMIT: cfg_in.bounce_limit = csr_wdata[CNT_W-1:0];
            CSR_STALL_ENABLE: cfg_in.stall_enable = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_rate   <= RST_ACCEL_RATE;
         cfg_ff.decel_rate   <= RST_DECEL_RATE;
         cfg_ff.stop_speed   <= RST_STOP_SPEED;
         cfg_ff.stall_limit  <= RST_STALL_LIMIT;
         cfg_ff.bounce_limit <= RST_BOUNCE_LIMIT;
         cfg_ff.stall_enable <= RST_STALL_ENABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/core/mssr_ramp.sv
// ----------------------------------------------------------------------------
// Ramp step
// One tick of the reference ramp with fractional carry in hundredths.
// ----------------------------------------------------------------------------
`default_nettype none

module mssr_ramp (
   input  wire logic [mssr_pkg::SPEED_W-1:0] ramp_ref,
   input  wire logic [mssr_pkg::SPEED_W-1:0] target,
   input  wire logic [mssr_pkg::REM_W-1:0]   accel_rem,
   input  wire logic [mssr_pkg::REM_W-1:0]   decel_rem,
   input  wire logic [mssr_pkg::RATE_W-1:0]  accel_rate,
   input  wire logic [mssr_pkg::RATE_W-1:0]  decel_rate,
   output logic [mssr_pkg::SPEED_W-1:0]      ramp_ref_next,
   output logic [mssr_pkg::REM_W-1:0]        accel_rem_next,
   output logic [mssr_pkg::REM_W-1:0]        decel_rem_next
);
   import mssr_pkg::*;

   logic               ramp_up;
   logic               ramp_down;
   logic [ACC_W-1:0]   acc;
   logic [PROD_W-1:0]  prod;
   logic [STEP_W-1:0]  step;
   logic [ACC_W-1:0]   rem_wide;
   logic [SUM_W-1:0]   sum;
   logic [SPEED_W-1:0] gap;

   // Only one direction is active per tick, so a single divide by one hundred
   // is shared between the acceleration and deceleration accumulators.
   always_comb begin
      ramp_up   = target > ramp_ref;
      ramp_down = target < ramp_ref;
      if (ramp_up) begin
         acc = ACC_W'(accel_rate) + ACC_W'(accel_rem);
      end else begin
         acc = ACC_W'(decel_rate) + ACC_W'(decel_rem);
      end
      prod     = PROD_W'(acc) * PROD_W'(RECIP_MULT);
      step     = prod[RECIP_SHIFT +: STEP_W];
      rem_wide = acc - ACC_W'(step) * ACC_W'(RATE_SCALE);
      sum      = SUM_W'(ramp_ref) + SUM_W'(step);
      gap      = ramp_ref - target;
   end

   always_comb begin
      ramp_ref_next  = ramp_ref;
      accel_rem_next = accel_rem;
      decel_rem_next = decel_rem;
      if (ramp_up) begin
         accel_rem_next = rem_wide[REM_W-1:0];
         ramp_ref_next  = (sum > SUM_W'(target)) ? target : sum[SPEED_W-1:0];
      end else if (ramp_down) begin
         if (decel_rate == '0) begin
            ramp_ref_next = target;
         end else begin
            decel_rem_next = rem_wide[REM_W-1:0];
            ramp_ref_next  = (gap <= SPEED_W'(step)) ? target
                                                     : ramp_ref - SPEED_W'(step);
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/mssr_ctrl.sv
// ----------------------------------------------------------------------------
// Run state machine and stall supervisor
// Holds the ramp state and counters and forms the result of each tick.
// ----------------------------------------------------------------------------
`default_nettype none
`include "motor_speed_ramp_stall_controller_macros.svh"

module mssr_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire mssr_pkg::cfg_type             cfg,
   input  wire logic [mssr_pkg::CMD_W-1:0]    work_command,
   input  wire logic [mssr_pkg::SPEED_W-1:0]  speed_setpoint,
   input  wire logic [mssr_pkg::SPEED_W-1:0]  measured_speed,
   output mssr_pkg::rsp_item_type             result
);
   import mssr_pkg::*;

   run_state_type      state_ff,   state_in;
   logic [SPEED_W-1:0] ref_ff,     ref_in;
   logic [REM_W-1:0]   arem_ff,    arem_in;
   logic [REM_W-1:0]   drem_ff,    drem_in;
   logic [CNT_W-1:0]   stall_ff,   stall_in;
   logic [CNT_W-1:0]   bounce_ff,  bounce_in;

   work_cmd_type       cmd;
   logic               moving;
   logic               stop_done;
   logic               low_meas;
   logic               stall_trip;
   logic               int_clr;
   logic               fault;
   logic [SPEED_W-1:0] target;
   logic [SPEED_W-1:0] ramp_ref_next;
   logic [REM_W-1:0]   arem_next;
   logic [REM_W-1:0]   drem_next;

   assign cmd        = work_cmd_type'(work_command);
   assign moving     = (cmd == CMD_FORWARD) || (cmd == CMD_REVERSE);
   assign stop_done  = !moving && (ref_ff <= cfg.stop_speed);
   assign low_meas   = measured_speed < cfg.stop_speed;
   assign stall_trip = cfg.stall_enable && low_meas && (stall_ff >= cfg.stall_limit);
   assign target     = moving ? speed_setpoint : '0;

   mssr_ramp u_ramp (
      .ramp_ref       (ref_ff),
      .target         (target),
      .accel_rem      (arem_ff),
      .decel_rem      (drem_ff),
      .accel_rate     (cfg.accel_rate),
      .decel_rate     (cfg.decel_rate),
      .ramp_ref_next  (ramp_ref_next),
      .accel_rem_next (arem_next),
      .decel_rem_next (drem_next)
   );

   // Next state.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = moving ? ST_RUN : ST_IDLE;
         ST_RUN: begin
            if (stop_done) begin
               state_in = ST_IDLE;
            end else if (stall_trip) begin
               state_in = ST_ERR;
            end else begin
               state_in = ST_RUN;
            end
         end
         default: state_in = state_ff;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      int_clr   = 1'b0;
      fault     = 1'b0;
      ref_in    = ref_ff;
      arem_in   = arem_ff;
      drem_in   = drem_ff;
      stall_in  = stall_ff;
      bounce_in = bounce_ff;
      unique case (state_ff)
         ST_IDLE: int_clr = moving;
         ST_RUN: begin
            if (stop_done) begin
               int_clr  = 1'b1;
               ref_in   = '0;
               arem_in  = '0;
               drem_in  = '0;
               stall_in = '0;
            end else begin
               ref_in  = ramp_ref_next;
               arem_in = arem_next;
               drem_in = drem_next;
               if (cfg.stall_enable) begin
                  if (low_meas) begin
                     bounce_in = '0;
                     if (stall_trip) begin
                        stall_in = '0;
                        fault    = 1'b1;
                     end else begin
                        stall_in = stall_ff + 1'b1;
                     end
                  end else if (bounce_ff < cfg.bounce_limit) begin
                     bounce_in = bounce_ff + 1'b1;
                  end else begin
                     bounce_in = '0;
                     stall_in  = '0;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ref_ff    <= '0;
         arem_ff   <= '0;
         drem_ff   <= '0;
         stall_ff  <= '0;
         bounce_ff <= '0;
      end else if (advance) begin
         state_ff  <= state_in;
         ref_ff    <= ref_in;
         arem_ff   <= arem_in;
         drem_ff   <= drem_in;
         stall_ff  <= stall_in;
         bounce_ff <= bounce_in;
      end
   end

   assign result.reference_speed  = ref_in;
   assign result.motor_state      = state_in;
   assign result.drive_enable     = (state_in == ST_RUN);
   assign result.integrator_clear = int_clr;
   assign result.stall_fault      = fault;

   `MSSR_ASSERT_NEXT(a_err_sticky, clock, reset, state_ff == ST_ERR,
                     state_ff == ST_ERR, "stall error state was left without reset")
   `MSSR_ASSERT_NEXT(a_fault_enters_err, clock, reset, advance && fault,
                     state_ff == ST_ERR && stall_ff == '0,
                     "stall fault did not enter the error state")
   `MSSR_ASSERT_NEXT(a_stop_clears_ramp, clock, reset,
                     advance && state_ff == ST_RUN && stop_done,
                     ref_ff == '0 && arem_ff == '0 && drem_ff == '0,
                     "completed stop left ramp state behind")
   `MSSR_ASSERT_NEXT(a_no_overshoot, clock, reset,
                     advance && state_ff == ST_RUN && !stop_done && ref_ff <= target,
                     ref_ff <= $past(target), "ramp passed its target on the way up")
   `MSSR_ASSERT_NOW(a_rem_bound, clock, reset, 1'b1,
                    arem_ff < REM_W'(RATE_SCALE) && drem_ff < REM_W'(RATE_SCALE),
                    "ramp remainder reached a whole step")

endmodule

`default_nettype wire

### rtl/core/motor_speed_ramp_stall_controller.sv
// ----------------------------------------------------------------------------
// Motor speed ramp and stall controller
// Ramped speed reference with run state machine and stall supervision.
// ----------------------------------------------------------------------------
// Each request transfer is one control tick carrying the commanded work state,
// the speed setpoint and the measured speed, and each tick yields exactly one
// response transfer. The block takes one tick per clock cycle while results are
// taken: a tick is captured in an input register, the ramp step, the state
// machine and the stall counters are evaluated when the output register is free
// and the result lands in that output register. Throughput is set by the ramp
// step, whose divide by one hundred is a single constant multiply, so a new
// tick may follow in every cycle as long as results are taken; while a result
// waits in the output register, one further tick is held in the input
// register and the request side then stalls. Configuration registers may be
// written at any time the block holds no tick in flight; there is no clearing
// pass after reset. The stall error state is left only through reset.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_ramp_stall_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request stream. tdata, lowest bit up: work_command[1:0],
   // speed_setpoint[17:2], measured_speed[33:18], zero fill[39:34].
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [mssr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Response stream. tdata, lowest bit up: reference_speed[15:0],
   // motor_state[17:16], drive_enable[18], integrator_clear[19],
   // stall_fault[20], zero fill[23:21].
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [mssr_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // Configuration write port.
   input  wire logic                              csr_wr_en,
   input  wire logic [mssr_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  wire logic [mssr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mssr_pkg::*;

   localparam int RSP_USED_W = $bits(rsp_item_type);

   cfg_type            cfg;
   rsp_item_type       result;

   // Input stage: one tick waiting to be evaluated.
   logic               in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [SPEED_W-1:0] setpoint_ff;
   logic [SPEED_W-1:0] measured_ff;

   // Output stage: one finished result waiting for its transfer.
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       rsp_ff;

   logic               req_fire;
   logic               out_free;
   logic               advance;

   // The tick in the input stage is evaluated, and the state moves on, in the
   // cycle it is copied into the output stage.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff      <= req_tdata[CMD_W-1:0];
         setpoint_ff <= req_tdata[CMD_W +: SPEED_W];
         measured_ff <= req_tdata[CMD_W+SPEED_W +: SPEED_W];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   mssr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mssr_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .cfg            (cfg),
      .work_command   (cmd_ff),
      .speed_setpoint (setpoint_ff),
      .measured_speed (measured_ff),
      .result         (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_USED_W){1'b0}},
                        rsp_ff.stall_fault,
                        rsp_ff.integrator_clear,
                        rsp_ff.drive_enable,
                        rsp_ff.motor_state,
                        rsp_ff.reference_speed};

endmodule

`default_nettype wire

### tb/mssr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Speed ramp controller result checker
// Watches the tick, result and register write ports, predicts each result
// from its own model of the ramp, run state machine and stall supervision,
// and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module mssr_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [mssr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [mssr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [mssr_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  wire logic [mssr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int unsigned                            fail_count,
   output int unsigned                            backlog,
   output logic                                   stall_near
);
   import mssr_pkg::*;

   cfg_type            cfg;
   run_state_type      run_state;
   logic [SPEED_W-1:0] ramp_ref;
   logic [REM_W-1:0]   up_rem;
   logic [REM_W-1:0]   down_rem;
   logic [CNT_W-1:0]   stall_count;
   logic [CNT_W-1:0]   bounce_count;
   rsp_item_type       pending_results[$];
   int unsigned        mismatches = 0;

   assign fail_count = mismatches;

   // One ramp step towards the target, carrying the hundredths remainder.
   task automatic step_ramp(input logic [SPEED_W-1:0] target);
      logic [ACC_W-1:0]  acc;
      logic [STEP_W-1:0] step;
      logic [SUM_W-1:0]  sum;
      if (target > ramp_ref) begin
         acc = up_rem + cfg.accel_rate;
         step = STEP_W'(acc / RATE_SCALE);
         up_rem = REM_W'(acc - step * RATE_SCALE);
         sum = ramp_ref + step;
         ramp_ref = (sum > target) ? target : sum[SPEED_W-1:0];
      end else if (target < ramp_ref) begin
         if (cfg.decel_rate == '0) begin
            ramp_ref = target;
         end else begin
            acc = down_rem + cfg.decel_rate;
            step = STEP_W'(acc / RATE_SCALE);
            down_rem = REM_W'(acc - step * RATE_SCALE);
            if (ramp_ref - target <= step) begin
               ramp_ref = target;
            end else begin
               ramp_ref = ramp_ref - step;
            end
         end
      end
   endtask

   task automatic advance_tick(input work_cmd_type cmd, input logic [SPEED_W-1:0] setpoint,
                               input logic [SPEED_W-1:0] measured, output rsp_item_type res);
      logic moving;
      logic clear_int;
      logic fault;
      moving = (cmd == CMD_FORWARD) || (cmd == CMD_REVERSE);
      clear_int = 1'b0;
      fault = 1'b0;
      case (run_state)
         ST_IDLE: begin
            if (moving) begin
               run_state = ST_RUN;
               clear_int = 1'b1;
            end
         end
         ST_RUN: begin
            if (!moving && ramp_ref <= cfg.stop_speed) begin
               ramp_ref = '0;
               up_rem = '0;
               down_rem = '0;
               stall_count = '0;
               run_state = ST_IDLE;
               clear_int = 1'b1;
            end else begin
               step_ramp(moving ? setpoint : 16'd0);
               if (cfg.stall_enable) begin
                  if (measured < cfg.stop_speed) begin
                     if (stall_count < cfg.stall_limit) begin
                        stall_count = stall_count + 1'b1;
                     end else begin
                        stall_count = '0;
                        run_state = ST_ERR;
                        fault = 1'b1;
                     end
                     bounce_count = '0;
                  end else if (bounce_count < cfg.bounce_limit) begin
                     bounce_count = bounce_count + 1'b1;
                  end else begin
                     bounce_count = '0;
                     stall_count = '0;
                  end
               end
            end
         end
         default: ;
      endcase
      res.reference_speed = ramp_ref;
      res.motor_state = run_state;
      res.drive_enable = (run_state == ST_RUN);
      res.integrator_clear = clear_int;
      res.stall_fault = fault;
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         cfg = '{accel_rate: RST_ACCEL_RATE, decel_rate: RST_DECEL_RATE,
                 stop_speed: RST_STOP_SPEED, stall_limit: RST_STALL_LIMIT,
                 bounce_limit: RST_BOUNCE_LIMIT, stall_enable: RST_STALL_ENABLE};
         run_state = ST_IDLE;
         ramp_ref = '0;
         up_rem = '0;
         down_rem = '0;
         stall_count = '0;
         bounce_count = '0;
         pending_results.delete();
      end else begin
         // Results are matched before a new tick is queued, so a result can
         // never be paired with the tick accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with no result expected");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("reference_speed", want.reference_speed, rsp_tdata[15:0]);
               check_field("motor_state", want.motor_state, rsp_tdata[17:16]);
               check_field("drive_enable", want.drive_enable, rsp_tdata[18]);
               check_field("integrator_clear", want.integrator_clear, rsp_tdata[19]);
               check_field("stall_fault", want.stall_fault, rsp_tdata[20]);
            end
         end
         if (req_tvalid && req_tready) begin
            advance_tick(work_cmd_type'(req_tdata[1:0]), req_tdata[17:2], req_tdata[33:18],
                         want);
            pending_results.push_back(want);
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ACCEL_RATE:   cfg.accel_rate = csr_wdata[RATE_W-1:0];
               CSR_DECEL_RATE:   cfg.decel_rate = csr_wdata[RATE_W-1:0];
               CSR_STOP_SPEED:   cfg.stop_speed = csr_wdata[SPEED_W-1:0];
               CSR_STALL_LIMIT:  cfg.stall_limit = csr_wdata[CNT_W-1:0];
               CSR_BOUNCE_LIMIT: cfg.bounce_limit = csr_wdata[CNT_W-1:0];
               CSR_STALL_ENABLE: cfg.stall_enable = csr_wdata[0];
               default: ;
            endcase
         end
      end
      backlog <= pending_results.size();
      stall_near <= ({1'b0, stall_count} + 17'd3) > {1'b0, cfg.stall_limit};
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Speed ramp and stall controller testbench
// Drives control ticks and register settings into the controller with random
// gaps and result stalls, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module testbench;
   import mssr_pkg::*;

   // No transfer on either side for this many cycles means the block is hung.
   localparam int WATCHDOG_LIMIT = 500;
   // Cycles allowed after the last result before registers change or the run
   // ends.
   localparam int SETTLE_CYCLES = 6;
   // Register indexes that the block does not decode; writes there must be
   // ignored.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_B = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned fail_count;
   int unsigned backlog;
   logic        stall_near;

   // Copies of the settings that shape the stimulus.
   logic [SPEED_W-1:0] cur_low = RST_STOP_SPEED;
   logic [RATE_W-1:0]  cur_accel = RST_ACCEL_RATE;

   int unsigned ticks_sent = 0;
   int unsigned quiet_cycles = 0;
   int unsigned rsp_hold = 0;
   bit          req_burst = 1'b0;
   bit          rsp_burst = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   motor_speed_ramp_stall_controller u_top (.*);

   mssr_checker u_checker (.*);

   // Result side back-pressure. After each transfer a fresh stall of random
   // length is drawn; now and then the side switches into a burst mode in
   // which it never stalls, so long unbroken runs occur as well.
   always @(posedge clock) begin
      int unsigned pause;
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_tready && rsp_tvalid) begin
         if ($urandom_range(0, 39) == 0) begin
            rsp_burst <= !rsp_burst;
         end
         pause = rsp_burst ? 0 : $urandom_range(0, 11);
         rsp_tready <= (pause == 0);
         rsp_hold <= pause;
      end else if (!rsp_tready) begin
         if (rsp_hold > 1) begin
            rsp_hold <= rsp_hold - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT - 1) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one tick after a random gap and returns at the edge where it is
   // taken. The valid is left high so that a following tick with no gap does
   // not see it dropped and raised within the same time step.
   task automatic send_tick(input work_cmd_type cmd, input logic [SPEED_W-1:0] setpoint,
                            input logic [SPEED_W-1:0] measured);
      int unsigned gap;
      gap = req_burst ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {measured, setpoint, cmd};
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   // Waits until every expected result has come back, then lets the block
   // settle. The first edge lets the checker count the tick just taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Holds the write enable high across back-to-back writes; the caller
   // lowers it after the last one.
   task automatic csr_put(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] accel, decel, low, stall_lim,
                                 input logic [CSR_DATA_W-1:0] bounce_lim, stall_en,
                                 input bit poke_spare);
      wait_drained();
      csr_put(CSR_ACCEL_RATE, accel);
      csr_put(CSR_DECEL_RATE, decel);
      csr_put(CSR_STOP_SPEED, low);
      csr_put(CSR_STALL_LIMIT, stall_lim);
      csr_put(CSR_BOUNCE_LIMIT, bounce_lim);
      csr_put(CSR_STALL_ENABLE, stall_en);
      if (poke_spare) begin
         csr_put(CSR_SPARE_A, 16'hFFFF);
         csr_put(CSR_SPARE_B, 16'($urandom()));
      end
      csr_wr_en <= 1'b0;
      cur_accel = accel[RATE_W-1:0];
      cur_low = low;
   endtask

   // Setpoints mostly sit where the ramp reaches them within a few dozen
   // ticks at the current acceleration, so that ramps settle and stops
   // complete; the rest cover the whole field.
   function automatic logic [SPEED_W-1:0] pick_setpoint();
      int unsigned span;
      int unsigned roll;
      span = cur_low + cur_accel * 30 / 100;
      if (span > 65535) begin
         span = 65535;
      end
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
         return 16'hFFFF;
      end
      if (roll < 3) begin
         return 16'($urandom());
      end
      return 16'($urandom_range(0, span));
   endfunction

   // The stall error can only be left through reset, so until the last phase
   // a slow measurement is withheld whenever the checker reports that the
   // stall count is close to its limit. In the last phase slow readings are
   // frequent so that the error is entered and its frozen outputs are seen.
   function automatic logic [SPEED_W-1:0] pick_measured(input bit allow_stall);
      logic [SPEED_W-1:0] speed;
      if (allow_stall && $urandom_range(0, 1) == 1) begin
         speed = 16'($urandom_range(0, cur_low));
      end else if ($urandom_range(0, 4) == 0) begin
         speed = 16'($urandom());
      end else begin
         speed = 16'($urandom_range(cur_low, 16'hFFFF));
      end
      if (!allow_stall && stall_near && speed < cur_low) begin
         speed = 16'($urandom_range(cur_low, 16'hFFFF));
      end
      return speed;
   endfunction

   // Random ticks in segments: run segments of forward or reverse with an
   // occasionally changing setpoint and direction, stop segments of idle or
   // stop commands, and single ticks of pure noise.
   task automatic run_phase(input int unsigned n_ticks, input bit allow_stall);
      int unsigned stop_at;
      int unsigned seg_len;
      int unsigned pick;
      work_cmd_type cmd;
      logic [SPEED_W-1:0] setpoint;
      stop_at = ticks_sent + n_ticks;
      while (ticks_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         seg_len = $urandom_range(1, 40);
         req_burst = ($urandom_range(0, 4) == 0);
         if (pick < 65) begin
            cmd = ($urandom_range(0, 1) == 1) ? CMD_FORWARD : CMD_REVERSE;
            setpoint = pick_setpoint();
            repeat (seg_len) begin
               if ($urandom_range(0, 9) == 0) begin
                  setpoint = pick_setpoint();
               end
               if ($urandom_range(0, 19) == 0) begin
                  cmd = (cmd == CMD_FORWARD) ? CMD_REVERSE : CMD_FORWARD;
               end
               send_tick(cmd, setpoint, pick_measured(allow_stall));
            end
         end else if (pick < 95) begin
            repeat (seg_len) begin
               send_tick(($urandom_range(0, 1) == 1) ? CMD_IDLE : CMD_STOP, 16'($urandom()),
                         pick_measured(allow_stall));
            end
         end else begin
            send_tick(work_cmd_type'($urandom_range(0, 3)), 16'($urandom()),
                      pick_measured(allow_stall));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks at the reset settings: one speed unit per tick up and
      // down, low speed of one hundred. Idle ticks from idle, a start with
      // the integrator clear, a ramp that settles on its target, a step down
      // towards a lower setpoint, a stop that completes at once and a start
      // in reverse ended by an idle command. Field extremes are included.
      send_tick(CMD_IDLE, 16'hFFFF, 16'hFFFF);
      send_tick(CMD_STOP, 16'h0000, 16'h0000);
      send_tick(CMD_FORWARD, 16'd3, 16'h0000);
      send_tick(CMD_FORWARD, 16'd3, 16'hFFFF);
      send_tick(CMD_FORWARD, 16'd3, 16'h0000);
      send_tick(CMD_REVERSE, 16'd3, 16'd150);
      send_tick(CMD_REVERSE, 16'd3, 16'd150);
      send_tick(CMD_FORWARD, 16'd1, 16'd99);
      send_tick(CMD_FORWARD, 16'd0, 16'd100);
      send_tick(CMD_STOP, 16'hFFFF, 16'hFFFF);
      send_tick(CMD_STOP, 16'hFFFF, 16'h0000);
      send_tick(CMD_REVERSE, 16'hFFFF, 16'hFFFF);
      send_tick(CMD_REVERSE, 16'hFFFF, 16'h0000);
      send_tick(CMD_REVERSE, 16'hFFFF, 16'hFFFF);
      send_tick(CMD_FORWARD, 16'hFFFF, 16'h0000);
      send_tick(CMD_FORWARD, 16'hFFFF, 16'hFFFF);
      send_tick(CMD_IDLE, 16'h0000, 16'h0000);

      run_phase(240, 1'b0);

      // Fastest acceleration (upper write bits set, so the rate field takes
      // its top value), jump-to-target deceleration, no low-speed band.
      apply_settings(16'hFFFF, 16'd0, 16'd0, 16'd3, 16'd2, 16'd1, 1'b0);
      run_phase(240, 1'b0);

      // No acceleration, fastest deceleration, widest low-speed band and
      // stall supervision off; the enable write carries junk above bit zero.
      apply_settings(16'd0, 16'd16383, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFE, 1'b0);
      run_phase(200, 1'b0);

      // Slow odd rates with remainders that carry for many ticks, a tight
      // stall budget and writes to the undecoded register indexes.
      apply_settings(16'd37, 16'd1, 16'd500, 16'd10, 16'd3, 16'd1, 1'b1);
      run_phase(240, 1'b0);

      // A hundred whole speed units per tick up and down and a zero stall budget.
      apply_settings(16'd10000, 16'd10000, 16'd1000, 16'd0, 16'hFFFF, 16'd1, 1'b0);
      run_phase(240, 1'b0);

      apply_settings(16'd1234, 16'd77, 16'd200, 16'd200, 16'd50, 16'd1, 1'b0);
      run_phase(240, 1'b0);

      // Last phase: the stall error is allowed and stays until the end.
      apply_settings(16'd300, 16'd250, 16'd300, 16'd15, 16'd4, 16'd1, 1'b0);
      run_phase(230, 1'b1);

      wait_drained();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
